/* rtl/sli_pkg.sv */
// shared types and constants for the sorted list insert unit
// no dependencies; used by sorted_list_insert_unit and its bench
package sli_pkg;

   localparam int CAPACITY   = 16;
   localparam int INDEX_W    = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;

   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_READOUT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                      mode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [POSITION_W-1:0]      position;
      logic signed [VALUE_W-1:0]  item_value;
      logic                       last;
   } rsp_type;

endpackage

/* rtl/sli_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module sli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/sorted_list_insert_unit.sv */
// sorted list insert unit: top level, state machine around one entry memory
// depends on sli_pkg and sli_ram
//
// keeps up to sli_pkg::CAPACITY signed 32-bit values in ascending order in a
// single memory with one write and one registered read port. a request is
// taken when start is high and busy is low. an insert walks down from the top
// of the list: each cycle it compares the entry read in the previous cycle
// with the new value, moves it up one place if it is greater or equal, and
// reads the next one down, until an entry below is smaller or the bottom is
// passed and it writes the new value into the place left free. a read-out
// returns one result per cycle, smallest first. inserts into a full or empty
// list and read-outs of an empty list answer at once. every result appears on
// rsp_data for exactly one cycle with rsp_strobe high, in the cycle after the
// work that caused it; the receiver cannot hold results off, and the final
// result of a request has last set. memory contents need no clearing after
// reset: only entries below the fill count are ever read
module sorted_list_insert_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sli_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sli_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      IDLE,
      SHIFT,
      PLACE,
      READOUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [sli_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [sli_pkg::COUNT_W-1:0]        idx_ff, idx_in;
   logic signed [sli_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   sli_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   // memory port signals
   logic                        wr_en;
   logic [sli_pkg::INDEX_W-1:0] wr_addr;
   logic [sli_pkg::VALUE_W-1:0] wr_data;
   logic [sli_pkg::INDEX_W-1:0] rd_addr;
   logic [sli_pkg::VALUE_W-1:0] rd_data;

   // index arithmetic, sliced down to memory addresses below
   logic [sli_pkg::COUNT_W-1:0] idx_dec1, idx_dec2, idx_inc, count_dec;
   logic                        accept;
   logic                        full, empty;

   assign accept    = start && (state_ff == IDLE);
   assign idx_dec1  = idx_ff - sli_pkg::COUNT_W'(1);
   assign idx_dec2  = idx_ff - sli_pkg::COUNT_W'(2);
   assign idx_inc   = idx_ff + sli_pkg::COUNT_W'(1);
   assign count_dec = count_ff - sli_pkg::COUNT_W'(1);
   assign full      = (count_ff == sli_pkg::COUNT_W'(sli_pkg::CAPACITY));
   assign empty     = (count_ff == '0);

   sli_ram #(
      .WIDTH (sli_pkg::VALUE_W),
      .DEPTH (sli_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '{status: sli_pkg::STATUS_OK, position: '0, item_value: '0, last: 1'b1};
      wr_en         = 1'b0;
      wr_addr       = idx_ff[sli_pkg::INDEX_W-1:0];
      wr_data       = value_ff;
      rd_addr       = '0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               value_in = req_data.value;
               if (req_data.mode == sli_pkg::MODE_INSERT) begin
                  if (full) begin
                     // list full: value dropped
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = sli_pkg::STATUS_FULL;
                  end else if (empty) begin
                     // first entry goes straight in
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     wr_data       = req_data.value;
                     count_in      = sli_pkg::COUNT_W'(1);
                     rsp_strobe_in = 1'b1;
                  end else begin
                     // fetch the top entry and start walking down
                     rd_addr  = count_dec[sli_pkg::INDEX_W-1:0];
                     idx_in   = count_ff;
                     state_in = SHIFT;
                  end
               end else begin
                  if (empty) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = sli_pkg::STATUS_EMPTY;
                  end else begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = READOUT;
                  end
               end
            end
         end

         SHIFT: begin
            // rd_data holds the entry just below idx_ff
            wr_en = 1'b1;
            if ($signed(rd_data) >= value_ff) begin
               // move it up; ties stay above the new value
               wr_data = rd_data;
               idx_in  = idx_dec1;
               if (idx_ff == sli_pkg::COUNT_W'(1)) begin
                  state_in = PLACE;
               end else begin
                  rd_addr = idx_dec2[sli_pkg::INDEX_W-1:0];
               end
            end else begin
               wr_data                = value_ff;
               count_in               = count_ff + sli_pkg::COUNT_W'(1);
               rsp_strobe_in          = 1'b1;
               rsp_data_in.position   = sli_pkg::POSITION_W'(idx_ff);
               state_in               = IDLE;
            end
         end

         PLACE: begin
            // new value is the smallest
            wr_en                = 1'b1;
            wr_data              = value_ff;
            count_in             = count_ff + sli_pkg::COUNT_W'(1);
            rsp_strobe_in        = 1'b1;
            rsp_data_in.position = sli_pkg::POSITION_W'(idx_ff);
            state_in             = IDLE;
         end

         READOUT: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.position   = sli_pkg::POSITION_W'(idx_ff);
            rsp_data_in.item_value = rd_data;
            rsp_data_in.last       = (idx_ff == count_dec);
            if (idx_ff == count_dec) begin
               state_in = IDLE;
            end else begin
               rd_addr = idx_inc[sli_pkg::INDEX_W-1:0];
               idx_in  = idx_inc;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // fill count never runs past the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sli_pkg::COUNT_W'(sli_pkg::CAPACITY))
      else $error("fill count above capacity");

   // fill count only ever grows by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + sli_pkg::COUNT_W'(1)))
      else $error("fill count changed by more than one");

   // a full status is only given when the list really is full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_data_ff.status == sli_pkg::STATUS_FULL))
         |-> (count_ff == sli_pkg::COUNT_W'(sli_pkg::CAPACITY)))
      else $error("full status on a list that is not full");

   // memory is written only by a request in progress or one being taken
   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff != IDLE) || accept))
      else $error("memory write while idle");

   // every read-out cycle yields a result in the cycle after it
   a_readout_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == READOUT) |=> rsp_strobe_ff)
      else $error("read-out cycle without a result");

endmodule

/* bench/sorted_list_insert_unit_tb.sv */
// self-checking bench for sorted_list_insert_unit: a directed table then random requests
// depends on sli_pkg and the rtl of sorted_list_insert_unit; every answer checked in order
module sorted_list_insert_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 250;
   // no idling at all for the final stretch of requests
   localparam int CALM_TAIL       = 40;
   // longest legal silence is an insert walking the whole list after an idle gap
   localparam int QUIET_LIMIT     = 2000;

   // one row of the directed table; typed rows carry their single answer by hand
   typedef struct packed {
      logic                               mode;
      logic signed [sli_pkg::VALUE_W-1:0] value;
      logic                               typed;
      sli_pkg::status_type                status;
      logic [sli_pkg::POSITION_W-1:0]     position;
      logic signed [sli_pkg::VALUE_W-1:0] item_value;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   sli_pkg::req_type req_data;
   logic             rsp_strobe;
   sli_pkg::rsp_type rsp_data;

   // shadow copy of the list as the block should hold it
   logic signed [sli_pkg::VALUE_W-1:0] shadow_list [sli_pkg::CAPACITY];
   int                                 shadow_count;

   // answers still owed by the block, oldest first
   sli_pkg::rsp_type pending_answers [$];
   plan_row_type     directed_plan [$];

   int requests_taken;
   int inserts_placed;
   int full_drops;
   int readouts;
   int answers_checked;
   int failures;
   int quiet_cycles;

   sorted_list_insert_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // works out the answers a request causes and updates the shadow list;
   // with record low only the state moves (the caller supplies the answer)
   function automatic void compute_answers(input sli_pkg::req_type req, input bit record);
      sli_pkg::rsp_type answer;
      int               slot;
      int               k;
      answer      = '0;
      answer.last = 1'b1;
      if (req.mode == sli_pkg::MODE_INSERT) begin
         if (shadow_count >= sli_pkg::CAPACITY) begin
            // full list: value dropped, state untouched
            answer.status = sli_pkg::STATUS_FULL;
            full_drops++;
         end else begin
            // first entry >= new value, so a tie lands ahead of its equals
            slot = 0;
            while (slot < shadow_count && $signed(shadow_list[slot]) < $signed(req.value))
               slot++;
            for (k = shadow_count; k > slot; k--)
               shadow_list[k] = shadow_list[k-1];
            shadow_list[slot] = req.value;
            shadow_count++;
            answer.status   = sli_pkg::STATUS_OK;
            answer.position = sli_pkg::POSITION_W'(slot);
            inserts_placed++;
         end
         if (record)
            pending_answers.push_back(answer);
      end else begin
         readouts++;
         if (shadow_count == 0) begin
            answer.status = sli_pkg::STATUS_EMPTY;
            if (record)
               pending_answers.push_back(answer);
         end else begin
            for (k = 0; k < shadow_count; k++) begin
               answer.status     = sli_pkg::STATUS_OK;
               answer.position   = sli_pkg::POSITION_W'(k);
               answer.item_value = shadow_list[k];
               answer.last       = (k == shadow_count - 1);
               if (record)
                  pending_answers.push_back(answer);
            end
         end
      end
   endfunction

   function automatic void add_row(input logic mode,
                                   input logic signed [sli_pkg::VALUE_W-1:0] value,
                                   input logic typed, input sli_pkg::status_type status,
                                   input int position,
                                   input logic signed [sli_pkg::VALUE_W-1:0] item);
      plan_row_type row;
      row.mode       = mode;
      row.value      = value;
      row.typed      = typed;
      row.status     = status;
      row.position   = sli_pkg::POSITION_W'(position);
      row.item_value = item;
      directed_plan.push_back(row);
   endfunction

   // presents a request from the next falling edge and holds it until taken
   task automatic send_request(input sli_pkg::req_type req);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= req;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      requests_taken++;
   endtask

   // drops start for a burst of cycles, with junk on the data lines
   task automatic idle_for(input int cycles);
      sli_pkg::req_type junk;
      junk.mode  = 1'($urandom_range(0, 1));
      junk.value = $urandom;
      @(negedge clock);
      start    <= 1'b0;
      req_data <= junk;
      repeat (cycles - 1) @(negedge clock);
   endtask

   function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 20)) - 10;
         1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // answer checker: every strobed answer must match the oldest one owed
   always @(posedge clock) begin : answer_check
      sli_pkg::rsp_type wanted;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer status=%0d position=%0d item_value=%0d last=%0d",
                     $time, rsp_data.status, rsp_data.position, rsp_data.item_value,
                     rsp_data.last);
            failures++;
         end else begin
            wanted = pending_answers.pop_front();
            answers_checked++;
            if (rsp_data.status !== wanted.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, wanted.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.position !== wanted.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, wanted.position, rsp_data.position);
               failures++;
            end
            if (rsp_data.item_value !== wanted.item_value) begin
               $display("%0t: item_value expected %0d actual %0d",
                        $time, wanted.item_value, rsp_data.item_value);
               failures++;
            end
            if (rsp_data.last !== wanted.last) begin
               $display("%0t: last expected %0d actual %0d",
                        $time, wanted.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   // watchdog: too long with neither a request taken nor an answer strobed
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      sli_pkg::req_type req;
      sli_pkg::rsp_type answer;
      plan_row_type     row;
      bit               calm;
      int               n;

      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      quiet_cycles    = 0;
      requests_taken  = 0;
      inserts_placed  = 0;
      full_drops      = 0;
      readouts        = 0;
      answers_checked = 0;
      failures        = 0;
      shadow_count    = 0;
      calm            = 1'b0;

      // directed table: empty read-out, extremes, ties, both bit patterns,
      // then fill to capacity and knock on the full list
      add_row(sli_pkg::MODE_READOUT, 0,              1'b1, sli_pkg::STATUS_EMPTY, 0, 0);
      add_row(sli_pkg::MODE_INSERT,  0,              1'b1, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_READOUT, 0,              1'b1, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh7fff_ffff, 1'b1, sli_pkg::STATUS_OK,    1, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh8000_0000, 1'b1, sli_pkg::STATUS_OK,    0, 0);
      // tie mid list
      add_row(sli_pkg::MODE_INSERT,  0,              1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  -1,             1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  1,              1'b0, sli_pkg::STATUS_OK,    0, 0);
      // tie at the top
      add_row(sli_pkg::MODE_INSERT,  32'sh7fff_ffff, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      // tie at the bottom
      add_row(sli_pkg::MODE_INSERT,  32'sh8000_0000, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh5555_5555, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'shaaaa_aaaa, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_READOUT, 32'sh1234_5678, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh4000_0000, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'shc000_0000, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  2,              1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  -2,             1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh1234_5678, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'shfedc_ba98, 1'b0, sli_pkg::STATUS_OK,    0, 0);
      // sixteen entries held now, so further inserts are dropped
      add_row(sli_pkg::MODE_INSERT,  7,              1'b1, sli_pkg::STATUS_FULL,  0, 0);
      add_row(sli_pkg::MODE_INSERT,  32'sh8000_0000, 1'b1, sli_pkg::STATUS_FULL,  0, 0);
      add_row(sli_pkg::MODE_READOUT, 0,              1'b0, sli_pkg::STATUS_OK,    0, 0);

      // reset held high from the start, released on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if ($urandom_range(0, 2) == 0)
            idle_for($urandom_range(1, 10));
         req.mode  = row.mode;
         req.value = row.value;
         send_request(req);
         compute_answers(req, !row.typed);
         if (row.typed) begin
            answer            = '0;
            answer.status     = row.status;
            answer.position   = row.position;
            answer.item_value = row.item_value;
            answer.last       = 1'b1;
            pending_answers.push_back(answer);
         end
      end

      // random part: read-outs now return the full list with gaps landing
      // inside the walk, inserts check the drop on a full list
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 20 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (!calm && n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 2) == 0)
            idle_for($urandom_range(1, 10));
         req.mode  = ($urandom_range(0, 2) == 0) ? sli_pkg::MODE_READOUT
                                                 : sli_pkg::MODE_INSERT;
         req.value = pick_value();
         send_request(req);
         compute_answers(req, 1'b1);
      end

      @(negedge clock);
      start <= 1'b0;

      // drain what is owed, then give the block time to show anything extra
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (sli_pkg::CAPACITY + 4) @(posedge clock);

      $display("run took %0d requests: %0d placed, %0d dropped as full, %0d read-outs",
               requests_taken, inserts_placed, full_drops, readouts);
      $display("%0d answers compared, %0d mismatches", answers_checked, failures);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sorted_list_insert_unit.sv
bench/sorted_list_insert_unit_tb.sv
